>>> rtl/core/asterix_cat010_record_splitter_top_macros.svh
// assertion macros used by the record splitter checker
`ifndef ASTERIX_CAT010_RECORD_SPLITTER_TOP_MACROS_SVH
`define ASTERIX_CAT010_RECORD_SPLITTER_TOP_MACROS_SVH

// checked only while out of reset
`define AC10RS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define AC10RS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/ac10rs_pkg.sv
// types, codes and the per-item length table of the record splitter
package ac10rs_pkg;

  localparam int unsigned FSPEC_W    = 32;
  localparam int unsigned REF_W      = 5;
  localparam int unsigned OFFSET_W   = 11;
  localparam int unsigned LAST_FRN   = 25;
  localparam int unsigned FRN_PER_OCT = 7;
  localparam logic [OFFSET_W-1:0] OFFSET_TOP = 11'd2040;

  typedef enum logic [2:0] {
    ROLE_CAT     = 3'd0,
    ROLE_LEN_HI  = 3'd1,
    ROLE_LEN_LO  = 3'd2,
    ROLE_FSPEC   = 3'd3,
    ROLE_ITEM    = 3'd4,
    ROLE_REP_CNT = 3'd5,
    ROLE_TRAIL   = 3'd6
  } role_e;

  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_EXT   = 2'd1,
    KIND_REP8  = 2'd2,
    KIND_REP2  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] len;
  } frn_info_t;

  typedef struct packed {
    logic [7:0]          byte_out;
    role_e               byte_role;
    logic [REF_W-1:0]    item_ref;
    logic [OFFSET_W-1:0] item_offset;
    logic                item_last;
    logic                record_done;
  } result_t;

  // item length by field reference number; variable items carry a kind instead
  function automatic frn_info_t frn_info(input logic [REF_W-1:0] frn);
    frn_info_t r;
    r.kind = KIND_FIXED;
    r.len  = 4'd1;
    unique case (frn)
      5'd1:    r.len = 4'd2;
      5'd2:    r.len = 4'd1;
      5'd3:    r.kind = KIND_EXT;
      5'd4:    r.len = 4'd3;
      5'd5:    r.len = 4'd8;
      5'd6:    r.len = 4'd4;
      5'd7:    r.len = 4'd4;
      5'd8:    r.len = 4'd4;
      5'd9:    r.len = 4'd4;
      5'd10:   r.len = 4'd2;
      5'd11:   r.kind = KIND_EXT;
      5'd12:   r.len = 4'd2;
      5'd13:   r.len = 4'd3;
      5'd14:   r.len = 4'd7;
      5'd15:   r.kind = KIND_REP8;
      5'd16:   r.len = 4'd1;
      5'd17:   r.len = 4'd2;
      5'd18:   r.len = 4'd2;
      5'd19:   r.kind = KIND_EXT;
      5'd20:   r.len = 4'd1;
      5'd21:   r.len = 4'd1;
      5'd22:   r.len = 4'd4;
      5'd23:   r.kind = KIND_REP2;
      5'd24:   r.len = 4'd1;
      5'd25:   r.len = 4'd2;
      default: r.len = 4'd1;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/asterix_cat010_record_splitter_top.sv
// record splitter top level: per-byte parse state and registered output with skid stage
//
// Takes one record byte per transaction on the s_axis side; tuser high marks
// the category byte and restarts the record. Each byte comes out once on the
// m_axis side, passed through with its role (tuser), item reference, offset
// within the item and an item-last mark (tdata), and tlast on the final byte
// of the parsed items, or of the FSPEC when it names none. Bytes after the last item are tagged trailing until the
// next record start.
// The output is registered. One byte per cycle is sustained while the receiver
// takes the output: the parse state and the next-item search over the FSPEC bits
// are updated in the cycle a byte is accepted, and the result lands in the output
// register. When the receiver stalls, one more byte is taken into a skid register,
// then s_axis_tready drops until the stalled transaction is taken and the skid
// byte has moved into the output register.
// Reset clears both output valids and puts the parser in the state expecting
// a category byte with an empty FSPEC.
module asterix_cat010_record_splitter_top #(
  parameter int unsigned MAX_FSPEC_OCTETS = 4,
  parameter int unsigned MAX_EXT_OCTETS   = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] record_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] byte_out, [12:8] item_ref,
                                      // [23:13] item_offset, [24] item_last
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_role
  output logic        m_axis_tlast    // record_done
);

  localparam int unsigned SEEN_W = $clog2(MAX_FSPEC_OCTETS + 1);
  localparam int unsigned OW     = ac10rs_pkg::OFFSET_W;
  localparam int unsigned RW     = ac10rs_pkg::REF_W;
  localparam int unsigned FW     = ac10rs_pkg::FSPEC_W;
  localparam int unsigned NFRN   = ac10rs_pkg::LAST_FRN;

  typedef enum logic [2:0] {
    PH_CAT, PH_LEN_HI, PH_LEN_LO, PH_FSPEC, PH_FIXED, PH_REP_CNT, PH_EXT, PH_TRAIL
  } phase_e;

  phase_e              phase_q, phase_d, phase_cur;
  logic [FW-1:0]       fspec_q, fspec_d;
  logic [SEEN_W-1:0]   seen_q, seen_d, seen_inc;
  logic [RW-1:0]       ref_q, ref_d, base_ref;
  logic [OW-1:0]       left_q, left_d;
  logic [OW-1:0]       pos_q, pos_d;
  logic                rep_long_q, rep_long_d;

  logic                accept;
  logic                out_load;
  logic [7:0]          data_byte;
  logic [4:0]          fspec_sh;
  logic                go_next;
  logic [NFRN:1]       present;
  logic [NFRN:1]       cand;
  logic                next_found;
  logic [RW-1:0]       next_ref;
  ac10rs_pkg::frn_info_t next_info;
  ac10rs_pkg::result_t res;

  logic                out_valid_q, skid_valid_q;
  ac10rs_pkg::result_t out_q, skid_q;

  assign data_byte     = s_axis_tdata;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = !out_valid_q || m_axis_tready;

  assign phase_cur = s_axis_tuser ? PH_CAT : phase_q;
  assign seen_inc  = seen_q + SEEN_W'(1);
  assign fspec_sh  = 5'd24 - {2'(seen_q), 3'b000};
  assign fspec_d   = (phase_cur == PH_FSPEC) ? (fspec_q | (FW'(data_byte) << fspec_sh))
                   : (phase_cur == PH_LEN_LO) ? '0 : fspec_q;
  assign base_ref  = (phase_cur == PH_FSPEC) ? '0 : ref_q;

  // fspec octet o holds items 7o+1..7o+7 from its top bit down; bit 0 is FX
  always_comb begin
    present = '0;
    for (int o = 0; o < 4; o++) begin
      for (int p = 0; p < 7; p++) begin
        if (o * 7 + p + 1 <= NFRN) begin
          present[o * 7 + p + 1] = fspec_d[FW - 1 - 8 * o - p];
        end
      end
    end
  end

  // lowest present item above the current one
  always_comb begin
    next_found = 1'b0;
    next_ref   = '0;
    for (int f = 1; f <= NFRN; f++) begin
      cand[f] = present[f] && (RW'(f) > base_ref);
    end
    for (int f = NFRN; f >= 1; f--) begin
      if (cand[f]) begin
        next_found = 1'b1;
        next_ref   = RW'(f);
      end
    end
  end

  assign next_info = ac10rs_pkg::frn_info(next_ref);

  always_comb begin
    phase_d    = phase_cur;
    seen_d     = seen_q;
    ref_d      = ref_q;
    left_d     = left_q;
    pos_d      = pos_q;
    rep_long_d = rep_long_q;
    go_next    = 1'b0;

    res.byte_out    = data_byte;
    res.byte_role   = ac10rs_pkg::ROLE_TRAIL;
    res.item_ref    = '0;
    res.item_offset = '0;
    res.item_last   = 1'b0;
    res.record_done = 1'b0;

    unique case (phase_cur)
      PH_CAT: begin
        res.byte_role = ac10rs_pkg::ROLE_CAT;
        phase_d       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        res.byte_role = ac10rs_pkg::ROLE_LEN_HI;
        phase_d       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        res.byte_role = ac10rs_pkg::ROLE_LEN_LO;
        seen_d        = '0;
        ref_d         = '0;
        phase_d       = PH_FSPEC;
      end
      PH_FSPEC: begin
        res.byte_role   = ac10rs_pkg::ROLE_FSPEC;
        res.item_offset = OW'(seen_q);
        seen_d          = seen_inc;
        if (!data_byte[0] || (seen_inc >= SEEN_W'(MAX_FSPEC_OCTETS))) begin
          res.item_last = 1'b1;
          go_next       = 1'b1;
        end
      end
      PH_FIXED: begin
        res.byte_role   = ac10rs_pkg::ROLE_ITEM;
        res.item_ref    = ref_q;
        res.item_offset = pos_q;
        if (left_q <= OW'(1)) begin
          res.item_last = 1'b1;
          go_next       = 1'b1;
        end else begin
          left_d = left_q - OW'(1);
          if (pos_q < ac10rs_pkg::OFFSET_TOP) begin
            pos_d = pos_q + OW'(1);
          end
        end
      end
      PH_REP_CNT: begin
        res.byte_role = ac10rs_pkg::ROLE_REP_CNT;
        res.item_ref  = ref_q;
        if (data_byte == 8'd0) begin
          res.item_last = 1'b1;
          go_next       = 1'b1;
        end else begin
          left_d  = rep_long_q ? OW'({data_byte, 3'b000}) : OW'({data_byte, 1'b0});
          pos_d   = OW'(1);
          phase_d = PH_FIXED;
        end
      end
      PH_EXT: begin
        res.byte_role   = ac10rs_pkg::ROLE_ITEM;
        res.item_ref    = ref_q;
        res.item_offset = pos_q;
        if (data_byte[0] && ((pos_q + OW'(1)) < OW'(MAX_EXT_OCTETS))) begin
          pos_d = pos_q + OW'(1);
        end else begin
          res.item_last = 1'b1;
          go_next       = 1'b1;
        end
      end
      PH_TRAIL: begin
        res.byte_role = ac10rs_pkg::ROLE_TRAIL;
      end
      default: begin
        res.byte_role = ac10rs_pkg::ROLE_TRAIL;
      end
    endcase

    if (go_next) begin
      if (next_found) begin
        ref_d = next_ref;
        pos_d = '0;
        unique case (next_info.kind)
          ac10rs_pkg::KIND_EXT:  phase_d = PH_EXT;
          ac10rs_pkg::KIND_REP8: begin
            rep_long_d = 1'b1;
            phase_d    = PH_REP_CNT;
          end
          ac10rs_pkg::KIND_REP2: begin
            rep_long_d = 1'b0;
            phase_d    = PH_REP_CNT;
          end
          ac10rs_pkg::KIND_FIXED: begin
            left_d  = OW'(next_info.len);
            phase_d = PH_FIXED;
          end
          default: phase_d = PH_FIXED;
        endcase
      end else begin
        res.record_done = 1'b1;
        ref_d           = '0;
        phase_d         = PH_TRAIL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CAT;
      fspec_q    <= '0;
      seen_q     <= '0;
      ref_q      <= '0;
      left_q     <= '0;
      pos_q      <= '0;
      rep_long_q <= 1'b1;
    end else if (accept) begin
      phase_q    <= phase_d;
      fspec_q    <= fspec_d;
      seen_q     <= seen_d;
      ref_q      <= ref_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      rep_long_q <= rep_long_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.item_last, out_q.item_offset, out_q.item_ref,
                          out_q.byte_out};
  assign m_axis_tuser  = out_q.byte_role;
  assign m_axis_tlast  = out_q.record_done;

endmodule

>>> rtl/core/ac10rs_checker.sv
// port-level checks for the record splitter, bound to its top level
`include "asterix_cat010_record_splitter_top_macros.svh"

module ac10rs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic hdr_role;
  logic item_role;

  assign hdr_role = (m_axis_tuser == ac10rs_pkg::ROLE_CAT)
                 || (m_axis_tuser == ac10rs_pkg::ROLE_LEN_HI)
                 || (m_axis_tuser == ac10rs_pkg::ROLE_LEN_LO)
                 || (m_axis_tuser == ac10rs_pkg::ROLE_FSPEC)
                 || (m_axis_tuser == ac10rs_pkg::ROLE_TRAIL);
  assign item_role = (m_axis_tuser == ac10rs_pkg::ROLE_ITEM)
                  || (m_axis_tuser == ac10rs_pkg::ROLE_REP_CNT);

  // a stalled transaction holds its payload
  `AC10RS_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output changed while stalled")
  // end of record always closes an item or the fspec
  `AC10RS_ASSERT(a_done_is_last, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[24], "record done without item last")
  // header, fspec and trailing bytes carry no item reference
  `AC10RS_ASSERT(a_hdr_ref_zero, m_axis_tvalid && hdr_role |-> m_axis_tdata[12:8] == 5'd0, "item reference on a header byte")
  // item and count bytes always name an item
  `AC10RS_ASSERT(a_item_ref_set, m_axis_tvalid && item_role |-> m_axis_tdata[12:8] != 5'd0, "item byte without reference")
  `AC10RS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind asterix_cat010_record_splitter_top ac10rs_checker u_ac10rs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
